@@ sv/smau_pkg.sv @@
// ----------------------------------------------------------------------------
// smau_pkg
// Shared constants, codes and types of the small matrix arithmetic unit.
// ----------------------------------------------------------------------------
package smau_pkg;

  localparam int MAX_DIM     = 4;
  localparam int FRAC_BITS   = 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam int DATA_W      = 32;
  localparam int OPC_W       = 3;
  localparam int POS_W       = 2;
  localparam int CFG_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = 64;

  typedef enum logic [OPC_W-1:0] {
    OP_WR_A  = 3'd0,
    OP_WR_B  = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_MUL   = 3'd4,
    OP_TRANS = 3'd5
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_COLS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_SUB  = 2'd1,
    ALU_PASS = 2'd2,
    ALU_MAC  = 2'd3
  } alu_mode_e;

  typedef struct packed {
    alu_mode_e mode;
    logic      ld_prod;
    logic      ld_acc;
    logic      acc_first;
  } alu_ctrl_t;

  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
  } store_req_t;

  // Row-major entry address with stride MAX_DIM.
  function automatic logic [ADDR_W-1:0] elem_addr(int row, int col);
    return ADDR_W'(row * MAX_DIM + col);
  endfunction

  // Clamp a dimension register to 1..MAX_DIM and return its last index.
  function automatic logic [IDX_W-1:0] dim_last(logic [CFG_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_DIM) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(int'(v) - 1);
    end
    return res;
  endfunction

endpackage

@@ sv/smau_if.sv @@
// ----------------------------------------------------------------------------
// smau_in_if / smau_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface smau_in_if;
  import smau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic [POS_W-1:0]         elem_row;
  logic [POS_W-1:0]         elem_col;
  logic signed [DATA_W-1:0] elem_value;

  modport source (output valid, output opcode, output elem_row, output elem_col,
                  output elem_value, input ready);
  modport sink   (input valid, input opcode, input elem_row, input elem_col,
                  input elem_value, output ready);
endinterface

interface smau_out_if;
  import smau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output out_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input out_last, output ready);
endinterface

@@ sv/smau_store.sv @@
// ----------------------------------------------------------------------------
// smau_store
// Element memories for matrices A and B, one write and one read port each.
// ----------------------------------------------------------------------------
module smau_store (
  input  logic                       clk_i,
  input  smau_pkg::store_req_t       req_i,
  output logic [smau_pkg::DATA_W-1:0] rd_data_a_o,
  output logic [smau_pkg::DATA_W-1:0] rd_data_b_o
);
  import smau_pkg::*;

  logic [DATA_W-1:0] mem_a [STORE_DEPTH];
  logic [DATA_W-1:0] mem_b [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we_a) begin
      mem_a[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_a_o <= mem_a[req_i.rd_addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we_b) begin
      mem_b[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_b_o <= mem_b[req_i.rd_addr_b];
  end

endmodule

@@ sv/smau_alu.sv @@
// ----------------------------------------------------------------------------
// smau_alu
// Shared multiplier, saturating accumulator and add/subtract unit.
// ----------------------------------------------------------------------------
module smau_alu (
  input  logic                               clk_i,
  input  smau_pkg::alu_ctrl_t                ctrl_i,
  input  logic signed [smau_pkg::DATA_W-1:0] a_i,
  input  logic signed [smau_pkg::DATA_W-1:0] b_i,
  output logic signed [smau_pkg::DATA_W-1:0] result_o
);
  import smau_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sh0000_0000_8000_0000);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W:0]    mac_sum;

  // Truncate toward minus infinity: arithmetic shift of the product.
  assign term    = ACC_W'(prod_q >>> FRAC_BITS);
  assign base    = ctrl_i.acc_first ? '0 : acc_q;
  assign mac_sum = (ACC_W+1)'(base) + (ACC_W+1)'(term);

  always_comb begin
    case (ctrl_i.mode)
      ALU_ADD:  acc_d = ACC_W'(a_i) + ACC_W'(b_i);
      ALU_SUB:  acc_d = ACC_W'(a_i) - ACC_W'(b_i);
      ALU_PASS: acc_d = ACC_W'(a_i);
      ALU_MAC: begin
        // clamp at the accumulator limits when the add overflows
        if (mac_sum[ACC_W] != mac_sum[ACC_W-1]) begin
          acc_d = mac_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          acc_d = mac_sum[ACC_W-1:0];
        end
      end
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.ld_acc) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    if (acc_q > SAT_MAX) begin
      result_o = DATA_W'(SAT_MAX);
    end else if (acc_q < SAT_MIN) begin
      result_o = DATA_W'(SAT_MIN);
    end else begin
      result_o = acc_q[DATA_W-1:0];
    end
  end

endmodule

@@ sv/smau_seq.sv @@
// ----------------------------------------------------------------------------
// smau_seq
// Sequencer: config registers, element walk, store and ALU control, output
// register.
// ----------------------------------------------------------------------------
module smau_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [smau_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [smau_pkg::CFG_W-1:0]         cfg_wdata_i,
  smau_in_if.sink                            in_ch,
  smau_out_if.source                         out_ch,
  output smau_pkg::store_req_t               store_req_o,
  output smau_pkg::alu_ctrl_t                alu_ctrl_o,
  input  logic signed [smau_pkg::DATA_W-1:0] alu_result_i
);
  import smau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_DATA,
    S_MAC,
    S_PUSH
  } state_e;

  state_e                   state_q;
  opcode_e                  op_q;
  logic [CFG_W-1:0]         a_rows_q, a_cols_q, b_cols_q;
  logic [IDX_W-1:0]         r_q, c_q, k_q;
  logic [IDX_W-1:0]         last_r_q, last_c_q, last_k_q;
  logic                     out_valid_q;
  logic [POS_W-1:0]         out_row_q, out_col_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_last_q;

  logic    in_fire;
  logic    wr_ok;
  opcode_e in_op;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_op       = opcode_e'(in_ch.opcode);
  assign wr_ok       = (int'(in_ch.elem_row) < MAX_DIM) && (int'(in_ch.elem_col) < MAX_DIM);

  assign out_ch.valid     = out_valid_q;
  assign out_ch.out_row   = out_row_q;
  assign out_ch.out_col   = out_col_q;
  assign out_ch.out_value = out_value_q;
  assign out_ch.out_last  = out_last_q;

  // Store access: writes straight from the accepted beat, reads from counters.
  always_comb begin
    store_req_o.we_a    = in_fire && (in_op == OP_WR_A) && wr_ok;
    store_req_o.we_b    = in_fire && (in_op == OP_WR_B) && wr_ok;
    store_req_o.wr_addr = elem_addr(int'(in_ch.elem_row), int'(in_ch.elem_col));
    store_req_o.wr_data = in_ch.elem_value;
    case (op_q)
      OP_MUL: begin
        store_req_o.rd_addr_a = elem_addr(int'(r_q), int'(k_q));
        store_req_o.rd_addr_b = elem_addr(int'(k_q), int'(c_q));
      end
      OP_TRANS: begin
        store_req_o.rd_addr_a = elem_addr(int'(c_q), int'(r_q));
        store_req_o.rd_addr_b = elem_addr(int'(r_q), int'(c_q));
      end
      default: begin
        store_req_o.rd_addr_a = elem_addr(int'(r_q), int'(c_q));
        store_req_o.rd_addr_b = elem_addr(int'(r_q), int'(c_q));
      end
    endcase
  end

  always_comb begin
    alu_ctrl_o.mode      = ALU_PASS;
    alu_ctrl_o.ld_prod   = 1'b0;
    alu_ctrl_o.ld_acc    = 1'b0;
    alu_ctrl_o.acc_first = (k_q == '0);
    case (state_q)
      S_DATA: begin
        case (op_q)
          OP_ADD:   alu_ctrl_o.mode = ALU_ADD;
          OP_SUB:   alu_ctrl_o.mode = ALU_SUB;
          OP_MUL:   alu_ctrl_o.mode = ALU_MAC;
          default:  alu_ctrl_o.mode = ALU_PASS;
        endcase
        alu_ctrl_o.ld_prod = (op_q == OP_MUL);
        alu_ctrl_o.ld_acc  = (op_q != OP_MUL);
      end
      S_MAC: begin
        alu_ctrl_o.mode   = ALU_MAC;
        alu_ctrl_o.ld_acc = 1'b1;
      end
      default: begin
        alu_ctrl_o.mode = ALU_PASS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ADD;
      a_rows_q    <= CFG_W'(4);
      a_cols_q    <= CFG_W'(4);
      b_cols_q    <= CFG_W'(4);
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      last_r_q    <= '0;
      last_c_q    <= '0;
      last_k_q    <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_A_ROWS: a_rows_q <= cfg_wdata_i;
          CFG_A_COLS: a_cols_q <= cfg_wdata_i;
          CFG_B_COLS: b_cols_q <= cfg_wdata_i;
          default:    ;
        endcase
      end

      // drop the output beat once taken; in the push state a taken beat is
      // replaced by the new load below
      if (out_valid_q && out_ch.ready && (state_q != S_PUSH)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          r_q      <= '0;
          c_q      <= '0;
          k_q      <= '0;
          last_k_q <= dim_last(a_cols_q);
          if (in_fire) begin
            case (in_op)
              OP_ADD, OP_SUB: begin
                op_q     <= in_op;
                last_r_q <= dim_last(a_rows_q);
                last_c_q <= dim_last(a_cols_q);
                state_q  <= S_ADDR;
              end
              OP_MUL: begin
                op_q     <= in_op;
                last_r_q <= dim_last(a_rows_q);
                last_c_q <= dim_last(b_cols_q);
                state_q  <= S_ADDR;
              end
              OP_TRANS: begin
                op_q     <= in_op;
                last_r_q <= dim_last(a_cols_q);
                last_c_q <= dim_last(a_rows_q);
                state_q  <= S_ADDR;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_ADDR: state_q <= S_DATA;
        S_DATA: state_q <= (op_q == OP_MUL) ? S_MAC : S_PUSH;
        S_MAC: begin
          if (k_q == last_k_q) begin
            state_q <= S_PUSH;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_ADDR;
          end
        end
        S_PUSH: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_row_q   <= POS_W'(r_q);
            out_col_q   <= POS_W'(c_q);
            out_value_q <= alu_result_i;
            out_last_q  <= (r_q == last_r_q) && (c_q == last_c_q);
            k_q         <= '0;
            if (c_q == last_c_q) begin
              c_q <= '0;
              if (r_q == last_r_q) begin
                state_q <= S_IDLE;
              end else begin
                r_q     <= r_q + 1'b1;
                state_q <= S_ADDR;
              end
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= S_ADDR;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/small_matrix_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// small_matrix_arithmetic_unit_top
// Two-matrix Q16.16 unit: element load, add, subtract, multiply, transpose.
// ----------------------------------------------------------------------------
// Load A and B one element per beat (opcode 0 or 1); such a beat gives no
// result. An operation beat (add, subtract, multiply, transpose A) streams
// the whole result matrix out in row-major order, one element per output
// beat, with out_last on the final element. The block works on one command
// at a time and drops ready until the last element has been loaded into the
// output register; that last beat may still wait at the output while the
// next command is taken. Per result element, add, subtract and transpose
// step through the address, read and push states; multiply steps through
// address, read and accumulate once per column of A before the push, as set
// by the single shared 32x32 multiplier and accumulator and the one read
// port of each element memory. An output stall holds the push. Products are
// truncated toward minus infinity to 16 fraction bits, accumulated with
// 64-bit saturation and then saturated to 32 bits; sums and differences
// saturate to 32 bits. Dimension registers clamp 0 to 1 and values above 4
// to 4; write them only while the block is idle. Elements must be written
// before they are read; the memories have no reset.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic_unit_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smau_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smau_pkg::CFG_W-1:0]     cfg_wdata_i,
  smau_in_if.sink                        in_ch,
  smau_out_if.source                     out_ch
);
  import smau_pkg::*;

  store_req_t               store_req;
  alu_ctrl_t                alu_ctrl;
  logic [DATA_W-1:0]        rd_data_a;
  logic [DATA_W-1:0]        rd_data_b;
  logic signed [DATA_W-1:0] alu_result;

  // Sequencer: walks rows, columns and the inner product index.
  smau_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .store_req_o  (store_req),
    .alu_ctrl_o   (alu_ctrl),
    .alu_result_i (alu_result)
  );

  // Element memories with registered read data.
  smau_store u_store (
    .clk_i       (clk_i),
    .req_i       (store_req),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // Shared arithmetic unit.
  smau_alu u_alu (
    .clk_i    (clk_i),
    .ctrl_i   (alu_ctrl),
    .a_i      (signed'(rd_data_a)),
    .b_i      (signed'(rd_data_b)),
    .result_o (alu_result)
  );

endmodule

@@ tb/tb_small_matrix_arithmetic_unit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_small_matrix_arithmetic_unit_top
// Self-checking bench for the small matrix unit: element loads, add, subtract,
// multiply and transpose under random handshake gaps and output back-pressure.
// A scoreboard keeps its own copies of A, B and the dimension registers and
// turns every accepted command beat into the result elements it must stream.
// ----------------------------------------------------------------------------
module tb_small_matrix_arithmetic_unit_top;
  import smau_pkg::*;

  localparam int     CLK_HALF_NS     = 2;
  localparam int     RESET_CYCLES    = 7;
  localparam int     SETTLE_CYCLES   = 16;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     PHASES          = 7;
  localparam int     PHASE_ITEMS     = 58;
  localparam int     TIMEOUT_NS      = 6_000_000;

  // Opcodes the block decodes as no-ops.
  localparam logic [OPC_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_RSVD_7 = 3'd7;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = -S64_MAX - 1;

  typedef struct {
    logic [OPC_W-1:0]         opcode;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } cmd_beat_t;

  typedef struct {
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } elem_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of both matrices and of the dimension registers, plus
  // the queue of result elements still owed by the block.
  // --------------------------------------------------------------------------
  class matrix_scoreboard;
    logic signed [DATA_W-1:0] mat_a [STORE_DEPTH];
    logic signed [DATA_W-1:0] mat_b [STORE_DEPTH];
    logic [CFG_W-1:0]         a_rows_reg;
    logic [CFG_W-1:0]         a_cols_reg;
    logic [CFG_W-1:0]         b_cols_reg;
    elem_beat_t               expected_elems [$];
    int                       error_count;

    function new();
      foreach (mat_a[i]) begin
        mat_a[i] = '0;
        mat_b[i] = '0;
      end
      a_rows_reg  = CFG_W'(MAX_DIM);
      a_cols_reg  = CFG_W'(MAX_DIM);
      b_cols_reg  = CFG_W'(MAX_DIM);
      error_count = 0;
    endfunction

    // Zero behaves as one, anything past MAX_DIM as MAX_DIM.
    function int dim_of(logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_A_ROWS: a_rows_reg = v;
        CFG_A_COLS: a_cols_reg = v;
        CFG_B_COLS: b_cols_reg = v;
        default: ;
      endcase
    endfunction

    function logic signed [DATA_W-1:0] a_at(int r, int c);
      return mat_a[r * MAX_DIM + c];
    endfunction

    function logic signed [DATA_W-1:0] b_at(int r, int c);
      return mat_b[r * MAX_DIM + c];
    endfunction

    function logic signed [DATA_W-1:0] sat32(longint v);
      if (v > S32_MAX) return S32_MAX[DATA_W-1:0];
      if (v < S32_MIN) return S32_MIN[DATA_W-1:0];
      return v[DATA_W-1:0];
    endfunction

    // Full product, floored to FRAC_BITS fraction bits.
    function longint mul_floor(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y);
      longint p;
      p = longint'(x) * longint'(y);
      return p >>> FRAC_BITS;
    endfunction

    function longint add_sat64(longint x, longint y);
      longint s;
      s = x + y;
      if (x[63] == y[63] && s[63] != x[63]) s = x[63] ? S64_MIN : S64_MAX;
      return s;
    endfunction

    // Apply one command beat: update a store, or queue the result matrix.
    function void accept_command(cmd_beat_t cmd);
      int                       ar, ac, bc, rows, cols, r, c, k;
      longint                   acc;
      logic signed [DATA_W-1:0] val;
      elem_beat_t               e;
      ar = dim_of(a_rows_reg);
      ac = dim_of(a_cols_reg);
      bc = dim_of(b_cols_reg);
      if (cmd.opcode == OP_WR_A) begin
        mat_a[int'(cmd.row) * MAX_DIM + int'(cmd.col)] = cmd.value;
        return;
      end
      if (cmd.opcode == OP_WR_B) begin
        mat_b[int'(cmd.row) * MAX_DIM + int'(cmd.col)] = cmd.value;
        return;
      end
      if (cmd.opcode > OP_TRANS) return;
      if (cmd.opcode == OP_MUL) begin
        rows = ar;
        cols = bc;
      end else if (cmd.opcode == OP_TRANS) begin
        rows = ac;
        cols = ar;
      end else begin
        rows = ar;
        cols = ac;
      end
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < cols; c++) begin
          case (cmd.opcode)
            OP_ADD: val = sat32(longint'(a_at(r, c)) + longint'(b_at(r, c)));
            OP_SUB: val = sat32(longint'(a_at(r, c)) - longint'(b_at(r, c)));
            OP_MUL: begin
              acc = 0;
              for (k = 0; k < ac; k++) acc = add_sat64(acc, mul_floor(a_at(r, k), b_at(k, c)));
              val = sat32(acc);
            end
            default: val = a_at(c, r);
          endcase
          e.row   = POS_W'(r);
          e.col   = POS_W'(c);
          e.value = val;
          e.last  = (r == rows - 1) && (c == cols - 1);
          expected_elems.push_back(e);
        end
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
    endtask

    task check_element(elem_beat_t got);
      elem_beat_t want;
      if (expected_elems.size() == 0) begin
        report_mismatch($sformatf("element (%0d,%0d) = %h arrived with nothing owed",
                                  got.row, got.col, got.value));
      end else begin
        want = expected_elems.pop_front();
        if (got.row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", got.row, want.row));
        if (got.col !== want.col)
          report_mismatch($sformatf("out_col %0d, want %0d", got.col, want.col));
        if (got.value !== want.value)
          report_mismatch($sformatf("out_value %h at (%0d,%0d), want %h",
                                    got.value, want.row, want.col, want.value));
        if (got.last !== want.last)
          report_mismatch($sformatf("out_last %b at (%0d,%0d), want %b",
                                    got.last, want.row, want.col, want.last));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  smau_in_if  cmd_if ();
  smau_out_if res_if ();

  small_matrix_arithmetic_unit_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (cmd_if),
    .out_ch      (res_if)
  );

  always begin
    #(CLK_HALF_NS) clk_i = 1'b1;
    #(CLK_HALF_NS) clk_i = 1'b0;
  end

  matrix_scoreboard sb;

  // Track which entries of A and B hold a value, so no operation ever reads
  // an entry that was never loaded.
  bit a_written [STORE_DEPTH];
  bit b_written [STORE_DEPTH];
  int items_sent;     // command beats the block acts on; no-op opcodes excluded
  bit cmd_burst;      // sender offers back to back while set
  bit hold_off_req;   // ask the result sink for one long stall

  // --------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered right after a rising edge.
  // --------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_cmd_gap();
    int pick;
    if (cmd_burst) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Element values: saturation corners, small Q16.16 numbers around zero so
  // that products stay in range, and raw random words.
  function automatic logic signed [DATA_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return S32_MAX[DATA_W-1:0];
      1:       return S32_MIN[DATA_W-1:0];
      2:       return '0;
      3, 4, 5: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one command beat and hold it until the block takes it. Lower valid
  // only when a gap comes first, so valid never drops and rises in one step.
  task automatic send_beat(cmd_beat_t cmd);
    int gap;
    gap = pick_cmd_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.opcode     <= cmd.opcode;
    cmd_if.elem_row   <= cmd.row;
    cmd_if.elem_col   <= cmd.col;
    cmd_if.elem_value <= cmd.value;
    @(posedge clk_i);
    while (cmd_if.ready !== 1'b1) @(posedge clk_i);
    sb.accept_command(cmd);
    if (cmd.opcode <= OP_TRANS) items_sent++;
  endtask

  task automatic put_elem(logic [OPC_W-1:0] op, int row, int col,
                          logic signed [DATA_W-1:0] v);
    cmd_beat_t cmd;
    cmd.opcode = op;
    cmd.row    = POS_W'(row);
    cmd.col    = POS_W'(col);
    cmd.value  = v;
    if (op == OP_WR_A) a_written[row * MAX_DIM + col] = 1'b1;
    else               b_written[row * MAX_DIM + col] = 1'b1;
    send_beat(cmd);
  endtask

  // Load any operand entry the next operation would read but that is still
  // empty. A is read over rows x cols in every case; B over the same window
  // for add and subtract, over a_cols x b_cols for multiply.
  task automatic ensure_operands(logic [OPC_W-1:0] op);
    int ar, ac, bc, r, c;
    ar = sb.dim_of(sb.a_rows_reg);
    ac = sb.dim_of(sb.a_cols_reg);
    bc = sb.dim_of(sb.b_cols_reg);
    for (r = 0; r < ar; r++)
      for (c = 0; c < ac; c++)
        if (!a_written[r * MAX_DIM + c]) put_elem(OP_WR_A, r, c, rand_value());
    if (op == OP_ADD || op == OP_SUB) begin
      for (r = 0; r < ar; r++)
        for (c = 0; c < ac; c++)
          if (!b_written[r * MAX_DIM + c]) put_elem(OP_WR_B, r, c, rand_value());
    end else if (op == OP_MUL) begin
      for (r = 0; r < ac; r++)
        for (c = 0; c < bc; c++)
          if (!b_written[r * MAX_DIM + c]) put_elem(OP_WR_B, r, c, rand_value());
    end
  endtask

  // Non-write opcode; the element fields are don't-care, so toggle them.
  task automatic run_op(logic [OPC_W-1:0] op);
    cmd_beat_t cmd;
    if (op >= OP_ADD && op <= OP_TRANS) ensure_operands(op);
    cmd.opcode = op;
    cmd.row    = POS_W'($urandom);
    cmd.col    = POS_W'($urandom);
    cmd.value  = $urandom;
    send_beat(cmd);
  endtask

  // Mostly a few loads followed by an operation; the rest is single loose
  // beats of any opcode, the no-op ones included.
  task automatic random_sequence();
    int               n, row, col;
    logic [OPC_W-1:0] op;
    if ($urandom_range(0, 99) < 80) begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        op = ($urandom_range(0, 1) != 0) ? OP_WR_B : OP_WR_A;
        if ($urandom_range(0, 9) < 7) begin
          row = $urandom_range(0, sb.dim_of(sb.a_rows_reg) - 1);
          col = $urandom_range(0, sb.dim_of(sb.a_cols_reg) - 1);
        end else begin
          row = $urandom_range(0, MAX_DIM - 1);
          col = $urandom_range(0, MAX_DIM - 1);
        end
        put_elem(op, row, col, rand_value());
      end
      run_op(OPC_W'($urandom_range(OP_ADD, OP_TRANS)));
    end else begin
      op = OPC_W'($urandom_range(0, 7));
      if (op == OP_WR_A || op == OP_WR_B)
        put_elem(op, $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                 rand_value());
      else
        run_op(op);
    end
  endtask

  // Stop offering, wait for every owed element, then give the block time to
  // finish a trailing load beat before anything else happens.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (sb.expected_elems.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three dimension registers on consecutive edges; keep the write
  // enable high across them and drop it once at the end.
  task automatic write_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                            logic [CFG_W-1:0] b_cols);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_A_ROWS;
    cfg_wdata_i <= rows;
    sb.write_reg(CFG_A_ROWS, rows);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_A_COLS;
    cfg_wdata_i <= cols;
    sb.write_reg(CFG_A_COLS, cols);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_B_COLS;
    cfg_wdata_i <= b_cols;
    sb.write_reg(CFG_B_COLS, b_cols);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_W-1:0] ar, ac, bc;
    int               quota;
    sb           = new();
    items_sent   = 0;
    cmd_burst    = 1'b0;
    hold_off_req = 1'b0;

    // Drive every input to a known value from time zero.
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_A_ROWS;
    cfg_wdata_i       <= '0;
    cmd_if.valid      <= 1'b0;
    cmd_if.opcode     <= OP_WR_A;
    cmd_if.elem_row   <= '0;
    cmd_if.elem_col   <= '0;
    cmd_if.elem_value <= '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 2x2 operands built from the saturation corners. Add hits
    // max+max and min+1, subtract min-1 and 1.0-min, multiply saturates the
    // top row, transpose swaps the min/1.0 pair.
    drain_results();
    write_dims(3'd2, 3'd2, 3'd2);
    put_elem(OP_WR_A, 0, 0, S32_MAX[DATA_W-1:0]);
    put_elem(OP_WR_A, 0, 1, S32_MIN[DATA_W-1:0]);
    put_elem(OP_WR_A, 1, 0, 32'sh0001_0000);
    put_elem(OP_WR_A, 1, 1, -32'sd1);
    put_elem(OP_WR_B, 0, 0, S32_MAX[DATA_W-1:0]);
    put_elem(OP_WR_B, 0, 1, 32'sd1);
    put_elem(OP_WR_B, 1, 0, S32_MIN[DATA_W-1:0]);
    put_elem(OP_WR_B, 1, 1, -32'sh0001_0000);
    // Far corner of the store, outside the current window.
    put_elem(OP_WR_A, MAX_DIM - 1, MAX_DIM - 1, 32'sh1234_5678);
    put_elem(OP_WR_B, MAX_DIM - 1, 0, -32'sh0000_8000);
    run_op(OP_ADD);
    run_op(OP_SUB);
    run_op(OP_MUL);
    run_op(OP_TRANS);
    // No-op opcodes must leave the stream untouched.
    run_op(OP_RSVD_6);
    run_op(OP_RSVD_7);
    run_op(OP_ADD);

    // Random phases, each under its own set of dimensions: full size, zero
    // and over-range register values, skinny shapes, then random values.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       begin ar = 3'd4; ac = 3'd4; bc = 3'd4; end
        1:       begin ar = 3'd0; ac = 3'd3; bc = 3'd7; end
        2:       begin ar = 3'd7; ac = 3'd1; bc = 3'd0; end
        3:       begin ar = 3'd3; ac = 3'd4; bc = 3'd2; end
        4:       begin ar = 3'd1; ac = 3'd2; bc = 3'd3; end
        default: begin
          ar = CFG_W'($urandom_range(0, 7));
          ac = CFG_W'($urandom_range(0, 7));
          bc = CFG_W'($urandom_range(0, 7));
        end
      endcase
      write_dims(ar, ac, bc);
      // Run one phase with no sender gaps at all.
      cmd_burst = (ph == 3);
      // Stall the result side for a long stretch while full-size results
      // are streaming, so the block backs up and drops its input ready.
      if (ph == 0) hold_off_req = 1'b1;
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) random_sequence();
    end

    cmd_burst = 1'b0;
    drain_results();
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: runs of ready, broken by gaps that are mostly short and
  // sometimes long; on request, one long hold-off counted here in cycles.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int run, gap, pick;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      gap = 0;
        else if (pick < 88) gap = $urandom_range(1, 3);
        else                gap = $urandom_range(8, 40);
        // Occasionally keep ready up long enough to cover whole matrices.
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        if (gap > 0) begin
          res_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        res_if.ready <= 1'b1;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Sample each result beat at the edge that moves it and check it.
  always @(posedge clk_i) begin : result_monitor
    elem_beat_t beat;
    if (rst_ni && res_if.valid && res_if.ready) begin
      beat.row   = res_if.out_row;
      beat.col   = res_if.out_col;
      beat.value = res_if.out_value;
      beat.last  = res_if.out_last;
      sb.check_element(beat);
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
